/* hw/rtl/adpcm_sample_encoder_defines.svh */
// Assertion macros for the ADPCM sample encoder checker.
// Needs clk and rst to be visible where the macros are used.
`ifndef ADPCM_SAMPLE_ENCODER_DEFINES_SVH
`define ADPCM_SAMPLE_ENCODER_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define SE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define SE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/adpcm_se_pkg.sv */
// Shared types, constants and tables for the ADPCM sample encoder.
// No dependencies.
package adpcm_se_pkg;

  localparam int unsigned INDEX_MAX = 88;
  localparam logic [6:0]  INDEX_MAX_7 = 7'(INDEX_MAX);
  localparam logic signed [15:0] PRED_MAX = 16'sh7fff;
  localparam logic signed [15:0] PRED_MIN = -16'sh8000;

  // Configuration register indexes
  localparam logic CFG_START_PREDICTOR  = 1'b0;
  localparam logic CFG_START_STEP_INDEX = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIFF,
    ST_QUANT,
    ST_UPDATE
  } state_t;

  localparam logic [14:0] STEP_TABLE [0:INDEX_MAX] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] s;
    if (idx > INDEX_MAX_7) begin
      s = STEP_TABLE[INDEX_MAX];
    end else begin
      s = STEP_TABLE[idx];
    end
    return s;
  endfunction

  // Step index adjustment per magnitude code
  function automatic logic signed [4:0] index_adjust(input logic [2:0] code);
    logic signed [4:0] a;
    case (code) inside
      [3'd0:3'd3]: a = -5'sd1;
      3'd4:        a = 5'sd2;
      3'd5:        a = 5'sd4;
      3'd6:        a = 5'sd6;
      default:     a = 5'sd8;
    endcase
    return a;
  endfunction

endpackage

/* hw/rtl/adpcm_sample_encoder.sv */
// ADPCM sample encoder: 16-bit PCM in, packed 4-bit codes out, two per byte.
// Depends on adpcm_se_pkg.
//
//  channel   handshake              payload
//  -------   ---------------------  ----------------------------------------------
//  in        in_valid / in_ready    pcm_sample, frame_start, frame_end
//  out       out_valid / out_ready  packed_byte, last_of_frame, predictor_now,
//                                   step_index_now
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A sample passes through accept, difference, three quantizer steps on the shared
// compare/subtract unit (one code bit each), then predictor and index update.
// in_ready is high only in the idle state, so the next sample waits until the update is done.
// The update waits while a byte to be emitted finds the previous one still untaken.
// Reset (rst, synchronous) clears predictor, step index, held nibble and phase.
// cfg_ready is always high.
module adpcm_sample_encoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] pcm_sample,
  input  logic               frame_start,
  input  logic               frame_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         packed_byte,
  output logic               last_of_frame,
  output logic signed [15:0] predictor_now,
  output logic [6:0]         step_index_now,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  adpcm_se_pkg::state_t state, state_next;

  logic signed [15:0] start_predictor;
  logic [6:0]         start_step_index;

  logic signed [15:0] predictor;
  logic [6:0]         step_index;
  logic [3:0]         held_nibble;
  logic               odd_phase;

  logic signed [15:0] sample;
  logic               fend;
  logic               sign;
  logic [14:0]        step;
  logic [17:0]        rem;
  logic [2:0]         code;
  logic [1:0]         qbit;

  logic               accept;
  logic               emit_need;
  logic               update_go;

  // Difference and magnitude
  logic signed [16:0] diff;
  logic [16:0]        diff_abs;

  // Shared compare/subtract unit
  logic [17:0]        trial;
  logic [18:0]        rem_sub;
  logic               bit_set;

  // Update path
  logic [17:0]        prod;
  logic [15:0]        recon;
  logic signed [17:0] pred_sum;
  logic signed [15:0] pred_sat;
  logic signed [7:0]  idx_sum;
  logic [6:0]         idx_sat;
  logic [3:0]         nib;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adpcm_se_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      adpcm_se_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = adpcm_se_pkg::ST_DIFF;
        end
      end
      adpcm_se_pkg::ST_DIFF: begin
        state_next = adpcm_se_pkg::ST_QUANT;
      end
      adpcm_se_pkg::ST_QUANT: begin
        if (qbit == 2'd0) begin
          state_next = adpcm_se_pkg::ST_UPDATE;
        end
      end
      adpcm_se_pkg::ST_UPDATE: begin
        if (update_go) begin
          state_next = adpcm_se_pkg::ST_IDLE;
        end
      end
      default: state_next = adpcm_se_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_predictor  <= '0;
      start_step_index <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        adpcm_se_pkg::CFG_START_PREDICTOR:  start_predictor  <= cfg_data;
        adpcm_se_pkg::CFG_START_STEP_INDEX: start_step_index <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign diff     = 17'(sample) - 17'(predictor);
  assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);

  assign trial   = 18'({3'b000, step} << qbit);
  assign rem_sub = {1'b0, rem} - {1'b0, trial};
  assign bit_set = !rem_sub[18];

  assign prod     = 18'(step) * 18'(code);
  assign recon    = prod[17:2] + {4'b0000, step[14:3]};
  assign pred_sum = sign ? (18'(predictor) - 18'({2'b00, recon}))
                         : (18'(predictor) + 18'({2'b00, recon}));
  assign pred_sat = (pred_sum > 18'(adpcm_se_pkg::PRED_MAX)) ? adpcm_se_pkg::PRED_MAX :
                    (pred_sum < 18'(adpcm_se_pkg::PRED_MIN)) ? adpcm_se_pkg::PRED_MIN :
                    pred_sum[15:0];
  assign idx_sum  = $signed({1'b0, step_index}) + 8'(adpcm_se_pkg::index_adjust(code));
  assign idx_sat  = idx_sum[7] ? 7'd0 :
                    (idx_sum > $signed({1'b0, adpcm_se_pkg::INDEX_MAX_7})) ?
                    adpcm_se_pkg::INDEX_MAX_7 : idx_sum[6:0];
  assign nib      = {sign, code};

  assign emit_need = odd_phase || fend;
  assign update_go = !emit_need || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      predictor   <= '0;
      step_index  <= '0;
      held_nibble <= '0;
      odd_phase   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (state == adpcm_se_pkg::ST_UPDATE && update_go && emit_need) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept && frame_start) begin
        predictor   <= start_predictor;
        step_index  <= (start_step_index > adpcm_se_pkg::INDEX_MAX_7) ?
                       adpcm_se_pkg::INDEX_MAX_7 : start_step_index;
        held_nibble <= '0;
        odd_phase   <= 1'b0;
      end
      if (state == adpcm_se_pkg::ST_UPDATE && update_go) begin
        predictor  <= pred_sat;
        step_index <= idx_sat;
        if (!emit_need) begin
          held_nibble <= nib;
          odd_phase   <= 1'b1;
        end else begin
          held_nibble <= '0;
          odd_phase   <= 1'b0;
        end
      end
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= pcm_sample;
      fend   <= frame_end;
    end
    unique case (state)
      adpcm_se_pkg::ST_DIFF: begin
        sign <= diff[16];
        step <= adpcm_se_pkg::step_size(step_index);
        rem  <= {diff_abs[15:0], 2'b00};
        code <= '0;
        qbit <= 2'd2;
      end
      adpcm_se_pkg::ST_QUANT: begin
        // one code bit per cycle, most significant first
        if (bit_set) begin
          rem        <= rem_sub[17:0];
          code[qbit] <= 1'b1;
        end
        qbit <= qbit - 2'd1;
      end
      adpcm_se_pkg::ST_UPDATE: begin
        if (update_go && emit_need) begin
          packed_byte    <= odd_phase ? {held_nibble, nib} : {nib, 4'b0000};
          last_of_frame  <= fend;
          predictor_now  <= pred_sat;
          step_index_now <= idx_sat;
        end
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/adpcm_se_checker.sv */
// Port-level checker for the ADPCM sample encoder, bound to the top level.
// Depends on adpcm_se_pkg and adpcm_sample_encoder_defines.svh.
`include "adpcm_sample_encoder_defines.svh"

module adpcm_se_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  packed_byte,
  input logic [6:0]  step_index_now
);

  // A stalled output beat keeps its byte.
  `SE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(packed_byte), "output beat changed while stalled")

  // Input ready drops once a beat is taken.
  `SE_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "input ready right after accept")

  // Reported step index stays inside the table.
  `SE_ASSERT(a_index_range, out_valid |-> step_index_now <= adpcm_se_pkg::INDEX_MAX_7, "step index beyond table")

  // Reset drops any pending output.
  `SE_ASSERT_RST(a_reset_clears, rst |=> !out_valid, "output valid after reset")

endmodule

bind adpcm_sample_encoder adpcm_se_checker u_adpcm_se_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .packed_byte    (packed_byte),
  .step_index_now (step_index_now)
);
